[hw/rtl/tle_pkg.sv]
// Shared types, character codes and helpers for the terminal line editor.
package tle_pkg;

  localparam int unsigned LINE_BUF = 64;
  localparam int unsigned IDX_W    = $clog2(LINE_BUF);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_CTRLU = 8'h15;
  localparam logic [7:0] CH_CTRLX = 8'h18;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_ONE   = 2'd1;
  localparam logic [1:0] ECHO_TWO   = 2'd2;
  localparam logic [1:0] ECHO_THREE = 2'd3;

  localparam logic [6:0] SIZE_RESET = 7'd64;

  // Byte class of the held input item
  typedef enum logic [2:0] {
    CL_NONE = 3'd0,
    CL_CHAR = 3'd1,
    CL_NL   = 3'd2,
    CL_RUB  = 3'd3,
    CL_KILL = 3'd4,
    CL_BEL  = 3'd5
  } cls_t;

  // Which result the datapath builds into the output register
  typedef enum logic [2:0] {
    RES_CHAR = 3'd0,
    RES_BEL  = 3'd1,
    RES_RUB  = 3'd2,
    RES_CRNL = 3'd3,
    RES_LINE = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic     take;
    logic     ld;
    res_sel_t sel;
    logic     last;
    logic     line_end;
    logic     store;
    logic     fill_dec;
    logic     fill_clr;
    logic     idx_clr;
    logic     idx_inc;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic fill_zero;
    logic fill_one;
    logic idx_last;
    logic out_free;
  } sts_t;

  // Capacity K = clamp(size, 2, LINE_BUF) - 1
  function automatic logic [IDX_W-1:0] cap_of(input logic [6:0] size);
    logic [6:0] s;
    begin
      s = size;
      if (s < 7'd2) s = 7'd2;
      if (s > 7'(LINE_BUF)) s = 7'(LINE_BUF);
      cap_of = IDX_W'(s - 7'd1);
    end
  endfunction

  function automatic cls_t classify(input logic [7:0] b);
    begin
      if (b == CH_NUL) classify = CL_NONE;
      else if ((b >= CH_SP && b <= CH_TILDE) || b == CH_HT) classify = CL_CHAR;
      else if (b == CH_NL) classify = CL_NL;
      else if (b == CH_BS || b == CH_DEL) classify = CL_RUB;
      else if (b == CH_CTRLU || b == CH_CTRLX) classify = CL_KILL;
      else classify = CL_BEL;
    end
  endfunction

endpackage

[hw/rtl/tle_dp.sv]
// Datapath: line memory, fill count, line size, read index and result register.
module tle_dp
  import tle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_rx_byte,
  input  logic       cfg_we,
  input  logic [6:0] cfg_line_size,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_echo_count,
  output logic [7:0] out_echo_byte_a,
  output logic [7:0] out_echo_byte_b,
  output logic [7:0] out_echo_byte_c,
  output logic       out_line_byte_valid,
  output logic [7:0] out_line_byte,
  output logic       out_line_end,
  output logic       out_last
);

  logic [7:0]       mem [LINE_BUF];
  logic [7:0]       byte_r;
  logic [6:0]       size_r;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] cap, new_cap;
  logic [7:0]       ch_val;
  logic             full;

  logic       oval_r, oval_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic [7:0] oa_r, oa_nxt, ob_r, ob_nxt, oc_r, oc_nxt;
  logic       olbv_r, olbv_nxt;
  logic [7:0] olb_r, olb_nxt;
  logic       oend_r, oend_nxt;
  logic       olast_r, olast_nxt;

  assign cap     = cap_of(size_r);
  assign new_cap = cap_of(cfg_line_size);
  assign ch_val  = (byte_r == CH_HT) ? CH_SP : byte_r;
  assign full    = (fill_r + IDX_W'(1)) == cap;

  // Status back to the controller
  assign sts.cls       = classify(byte_r);
  assign sts.fill_zero = (fill_r == '0);
  assign sts.fill_one  = (fill_r == IDX_W'(1));
  assign sts.idx_last  = (idx_r == fill_r - IDX_W'(1));
  assign sts.out_free  = !oval_r || !out_stall;

  // Fill count and read index
  always_comb begin
    fill_nxt = fill_r;
    if (cfg_we) begin
      if (fill_r > new_cap - IDX_W'(1)) fill_nxt = new_cap - IDX_W'(1);
    end else if (cmd.store) begin
      if (!full) fill_nxt = fill_r + IDX_W'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - IDX_W'(1);
    end else if (cmd.fill_clr) begin
      fill_nxt = '0;
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + IDX_W'(1);
  end

  // Build the next result
  always_comb begin
    oval_nxt  = oval_r && out_stall;
    ocnt_nxt  = ocnt_r;
    oa_nxt    = oa_r;
    ob_nxt    = ob_r;
    oc_nxt    = oc_r;
    olbv_nxt  = olbv_r;
    olb_nxt   = olb_r;
    oend_nxt  = oend_r;
    olast_nxt = olast_r;
    if (cmd.ld) begin
      oval_nxt  = 1'b1;
      ocnt_nxt  = ECHO_NONE;
      oa_nxt    = CH_NUL;
      ob_nxt    = CH_NUL;
      oc_nxt    = CH_NUL;
      olbv_nxt  = 1'b0;
      olb_nxt   = CH_NUL;
      oend_nxt  = cmd.line_end;
      olast_nxt = cmd.last;
      case (cmd.sel)
        RES_CHAR: begin
          oa_nxt = ch_val;
          if (full) begin
            ocnt_nxt = ECHO_THREE;
            ob_nxt   = CH_BEL;
            oc_nxt   = CH_BS;
          end else begin
            ocnt_nxt = ECHO_ONE;
          end
        end
        RES_BEL: begin
          ocnt_nxt = ECHO_ONE;
          oa_nxt   = CH_BEL;
        end
        RES_RUB: begin
          ocnt_nxt = ECHO_THREE;
          oa_nxt   = CH_BS;
          ob_nxt   = CH_SP;
          oc_nxt   = CH_BS;
        end
        RES_CRNL: begin
          ocnt_nxt = ECHO_TWO;
          oa_nxt   = CH_CR;
          ob_nxt   = CH_NL;
        end
        RES_LINE: begin
          olbv_nxt = 1'b1;
          olb_nxt  = rd_data_r;
        end
        default: begin
          ocnt_nxt = ECHO_NONE;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      fill_r <= '0;
      idx_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      if (cfg_we) size_r <= cfg_line_size;
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      oval_r <= oval_nxt;
    end
  end

  // Payload registers; map CR to NL on capture
  always_ff @(posedge clk) begin
    if (cmd.take) byte_r <= (in_rx_byte == CH_CR) ? CH_NL : in_rx_byte;
    ocnt_r  <= ocnt_nxt;
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
    oc_r    <= oc_nxt;
    olbv_r  <= olbv_nxt;
    olb_r   <= olb_nxt;
    oend_r  <= oend_nxt;
    olast_r <= olast_nxt;
  end

  // Line memory: one write port at the fill count, registered read at the index
  always_ff @(posedge clk) begin
    if (cmd.store) mem[fill_r] <= ch_val;
    rd_data_r <= mem[idx_r];
  end

  assign out_valid           = oval_r;
  assign out_echo_count      = ocnt_r;
  assign out_echo_byte_a     = oa_r;
  assign out_echo_byte_b     = ob_r;
  assign out_echo_byte_c     = oc_r;
  assign out_line_byte_valid = olbv_r;
  assign out_line_byte       = olb_r;
  assign out_line_end        = oend_r;
  assign out_last            = olast_r;

endmodule

[hw/rtl/tle_ctrl.sv]
// Controller: sequences one input item into its results.
module tle_ctrl
  import tle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic idle,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DEC  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_LB   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign idle     = (state_r == ST_IDLE);
  assign in_stall = !idle;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = RES_BEL;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        case (sts.cls) inside
          CL_CHAR, CL_BEL: begin
            if (sts.out_free) begin
              cmd.ld    = 1'b1;
              cmd.sel   = (sts.cls == CL_CHAR) ? RES_CHAR : RES_BEL;
              cmd.store = (sts.cls == CL_CHAR);
              cmd.last  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          CL_RUB: begin
            if (sts.fill_zero) begin
              state_nxt = ST_IDLE;
            end else if (sts.out_free) begin
              cmd.ld       = 1'b1;
              cmd.sel      = RES_RUB;
              cmd.last     = 1'b1;
              cmd.fill_dec = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
          CL_KILL: begin
            // one rubout per stored character, stay until the line is empty
            if (sts.fill_zero) begin
              state_nxt = ST_IDLE;
            end else if (sts.out_free) begin
              cmd.ld       = 1'b1;
              cmd.sel      = RES_RUB;
              cmd.last     = sts.fill_one;
              cmd.fill_dec = 1'b1;
              if (sts.fill_one) state_nxt = ST_IDLE;
            end
          end
          CL_NL: begin
            if (sts.out_free) begin
              cmd.ld       = 1'b1;
              cmd.sel      = RES_CRNL;
              cmd.last     = sts.fill_zero;
              cmd.line_end = sts.fill_zero;
              cmd.idx_clr  = 1'b1;
              state_nxt    = sts.fill_zero ? ST_IDLE : ST_RD;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RD: begin
        // wait for the registered memory read
        state_nxt = ST_LB;
      end
      ST_LB: begin
        if (sts.out_free) begin
          cmd.ld       = 1'b1;
          cmd.sel      = RES_LINE;
          cmd.last     = sts.idx_last;
          cmd.line_end = sts.idx_last;
          cmd.idx_inc  = 1'b1;
          cmd.fill_clr = sts.idx_last;
          state_nxt    = sts.idx_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/terminal_line_editor_core.sv]
// Top level of the terminal line editor: controller plus datapath.
//
//   Channel  Handshake           Payload
//   in_      in_valid/in_stall   in_rx_byte
//   out_     out_valid/out_stall echo count and bytes, line byte, line end, last
//   cfg_     cfg_valid/cfg_ready cfg_line_size
//
// Each item is sequenced to the end before the next is taken, and output
// stall holds it; kill line gives one rubout per stored character, newline
// gives CR NL and then the stored characters. Newline readout is paced
// by the single line memory and its registered read. Reset is synchronous,
// active low; it clears the fill count and sets the line size to 64, the line
// memory is not cleared.
// An item is taken only while the controller is idle; cfg_ready is high then.
module terminal_line_editor_core
  import tle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_echo_count,
  output logic [7:0] out_echo_byte_a,
  output logic [7:0] out_echo_byte_b,
  output logic [7:0] out_echo_byte_c,
  output logic       out_line_byte_valid,
  output logic [7:0] out_line_byte,
  output logic       out_line_end,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_line_size
);

  cmd_t cmd;
  sts_t sts;
  logic idle;

  assign cfg_ready = idle;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .idle     (idle),
    .sts      (sts),
    .cmd      (cmd)
  );

  tle_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_rx_byte          (in_rx_byte),
    .cfg_we              (cfg_valid && idle),
    .cfg_line_size       (cfg_line_size),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_echo_count      (out_echo_count),
    .out_echo_byte_a     (out_echo_byte_a),
    .out_echo_byte_b     (out_echo_byte_b),
    .out_echo_byte_c     (out_echo_byte_c),
    .out_line_byte_valid (out_line_byte_valid),
    .out_line_byte       (out_line_byte),
    .out_line_end        (out_line_end),
    .out_last            (out_last)
  );

endmodule

[hw/rtl/tle_checker.sv]
// Port-level checker for the terminal line editor, bound to the top level.
module tle_checker
  import tle_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_echo_count,
  input logic [7:0] out_line_byte,
  input logic       out_line_byte_valid,
  input logic       out_line_end,
  input logic       out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_byte) &&
    $stable(out_echo_count) && $stable(out_last))
    else $error("stalled result changed");

  // Line characters carry no echo bytes
  a_line_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_byte_valid |-> out_echo_count == ECHO_NONE)
    else $error("line byte with echo bytes");

  // A line end closes the item
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_last)
    else $error("line end without last");

  // A result without echo bytes carries a line character
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_count == ECHO_NONE |-> out_line_byte_valid)
    else $error("empty result");

endmodule

bind terminal_line_editor_core tle_checker u_tle_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_echo_count      (out_echo_count),
  .out_line_byte       (out_line_byte),
  .out_line_byte_valid (out_line_byte_valid),
  .out_line_end        (out_line_end),
  .out_last            (out_last)
);

[sim/tb.sv]
// Self-checking testbench for the terminal line editor core.
module tb;
  import tle_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLDOFF_CYCLES = 300;

  // One output item of the editor, field for field
  typedef struct {
    logic [1:0] echo_count;
    logic [7:0] echo_a;
    logic [7:0] echo_b;
    logic [7:0] echo_c;
    logic       line_valid;
    logic [7:0] line_char;
    logic       line_end;
    logic       last;
  } edit_result_t;

  // Line editing predictor plus the store of results still due from the block
  class line_editor_scoreboard;
    logic [7:0]   line_mem [LINE_BUF];
    int           fill;
    logic [6:0]   size_reg;
    edit_result_t due_results[$];
    int           errors;
    int           bytes_taken;
    int           results_seen;
    int           lines_done;
    int           overflows;

    function new();
      fill = 0;
      size_reg = SIZE_RESET;
      errors = 0;
      bytes_taken = 0;
      results_seen = 0;
      lines_done = 0;
      overflows = 0;
    endfunction

    // Usable slots: size clamped to 2..LINE_BUF, minus the terminator
    function int capacity();
      int s;
      s = size_reg;
      if (s < 2) s = 2;
      if (s > LINE_BUF) s = LINE_BUF;
      return s - 1;
    endfunction

    function void set_line_size(logic [6:0] sz);
      size_reg = sz;
      if (fill > capacity() - 1) fill = capacity() - 1;
    endfunction

    function void push(logic [1:0] cnt, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                       logic lv, logic [7:0] lc, logic lend, logic fin);
      edit_result_t r;
      r.echo_count = cnt;
      r.echo_a = a;
      r.echo_b = b;
      r.echo_c = c;
      r.line_valid = lv;
      r.line_char = lc;
      r.line_end = lend;
      r.last = fin;
      due_results.push_back(r);
    endfunction

    // Edit the line with one accepted byte and queue the results it causes
    function void take_byte(logic [7:0] rx);
      logic [7:0] ch;
      logic [7:0] v;
      int cap;
      int i;
      bytes_taken++;
      cap = capacity();
      if (fill > cap - 1) fill = cap - 1;
      ch = (rx == CH_CR) ? CH_NL : rx;
      if (ch == CH_NUL) begin
        return;
      end else if ((ch >= CH_SP && ch <= CH_TILDE) || ch == CH_HT) begin
        v = (ch == CH_HT) ? CH_SP : ch;
        line_mem[fill] = v;
        fill++;
        if (fill >= cap) begin
          // full line: back up so the next char overwrites the last slot
          fill = cap - 1;
          overflows++;
          push(ECHO_THREE, v, CH_BEL, CH_BS, 1'b0, 8'h00, 1'b0, 1'b1);
        end else begin
          push(ECHO_ONE, v, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
        end
      end else if (ch == CH_NL) begin
        lines_done++;
        push(ECHO_TWO, CH_CR, CH_NL, 8'h00, 1'b0, 8'h00, fill == 0, fill == 0);
        for (i = 0; i < fill; i++) begin
          push(ECHO_NONE, 8'h00, 8'h00, 8'h00, 1'b1, line_mem[i], i == fill - 1,
               i == fill - 1);
        end
        fill = 0;
      end else if (ch == CH_BS || ch == CH_DEL) begin
        if (fill == 0) return;
        push(ECHO_THREE, CH_BS, CH_SP, CH_BS, 1'b0, 8'h00, 1'b0, 1'b1);
        fill--;
      end else if (ch == CH_CTRLU || ch == CH_CTRLX) begin
        while (fill > 0) begin
          push(ECHO_THREE, CH_BS, CH_SP, CH_BS, 1'b0, 8'h00, 1'b0, fill == 1);
          fill--;
        end
      end else begin
        push(ECHO_ONE, CH_BEL, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
      end
    endfunction

    function void compare(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Match one output item against the oldest due result
    function void check_result(edit_result_t got);
      edit_result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        $error("output item with no result due (echo_count %0d, echo_a 0x%0h)",
               got.echo_count, got.echo_a);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare("echo_count", want.echo_count, got.echo_count);
      compare("echo_byte_a", want.echo_a, got.echo_a);
      compare("echo_byte_b", want.echo_b, got.echo_b);
      compare("echo_byte_c", want.echo_c, got.echo_c);
      compare("line_byte_valid", want.line_valid, got.line_valid);
      compare("line_byte", want.line_char, got.line_char);
      compare("line_end", want.line_end, got.line_end);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_echo_count;
  logic [7:0] out_echo_byte_a;
  logic [7:0] out_echo_byte_b;
  logic [7:0] out_echo_byte_c;
  logic       out_line_byte_valid;
  logic [7:0] out_line_byte;
  logic       out_line_end;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_line_size;

  line_editor_scoreboard sb;
  bit hold_request;
  int burst_left;
  int cycles;

  terminal_line_editor_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_echo_count      (out_echo_count),
    .out_echo_byte_a     (out_echo_byte_a),
    .out_echo_byte_b     (out_echo_byte_b),
    .out_echo_byte_c     (out_echo_byte_c),
    .out_line_byte_valid (out_line_byte_valid),
    .out_line_byte       (out_line_byte),
    .out_line_end        (out_line_end),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_line_size       (cfg_line_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Take output items and stall on a pattern of changing density
  initial begin : receiver
    int hold_left;
    int mode_left;
    int stall_pct;
    edit_result_t got;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.echo_count = out_echo_count;
        got.echo_a = out_echo_byte_a;
        got.echo_b = out_echo_byte_b;
        got.echo_c = out_echo_byte_c;
        got.line_valid = out_line_byte_valid;
        got.line_char = out_line_byte;
        got.line_end = out_line_end;
        got.last = out_last;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(5, 40);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one byte, maybe idling first when the current burst is used up
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.take_byte(b);
    burst_left--;
  endtask

  function automatic logic [7:0] random_text();
    if ($urandom_range(0, 7) == 0) return CH_HT;
    return 8'($urandom_range(32'h20, 32'h7E));
  endfunction

  // Hold input low until every due result is out and the block has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.due_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_size(input logic [6:0] sz);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_line_size <= sz;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_line_size(sz);
  endtask

  // Mostly words ended by newline, with rubouts, kills and raw noise mixed in
  task automatic send_random(input int n);
    int sent;
    int pick;
    int len;
    int j;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len && sent < n; j++) begin
          send_byte(random_text());
          sent++;
        end
      end else begin
        if (pick < 72) send_byte($urandom_range(0, 1) ? CH_CR : CH_NL);
        else if (pick < 80) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
        else if (pick < 86) send_byte($urandom_range(0, 1) ? CH_CTRLU : CH_CTRLX);
        else send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // Main sequence
  initial begin : stimulus
    static logic [7:0] directed[] = '{
      CH_NUL, 8'h41, CH_SP, CH_TILDE, CH_HT, CH_DEL, CH_BS, 8'h01, 8'hFF, 8'h80,
      CH_CR, CH_NL, CH_BS, CH_CTRLU, 8'h78, 8'h79, CH_CTRLX, 8'h61, 8'h62,
      CH_CTRLU, 8'h1B, 8'h5A, CH_NL
    };
    int i;
    sb = new();
    hold_request = 1'b0;
    burst_left = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_line_size <= SIZE_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every byte class, empty-line cases, both kill and rubout codes
    foreach (directed[k]) send_byte(directed[k]);

    // Tiny lines: a second char overflows at size 3, and every char overflows at size 2
    write_line_size(7'd3);
    send_byte(8'h70);
    send_byte(8'h71);
    send_byte(CH_CR);
    send_random(4);
    write_line_size(7'd2);
    send_random(4);

    // Largest line: fill past capacity, then read the whole line back
    write_line_size(7'd64);
    for (i = 0; i < 66; i++) send_byte(random_text());
    send_byte(CH_NL);

    // Leave text in the line so the next size write cuts it back
    write_line_size(7'd63);
    send_random(6);
    send_byte(CH_CTRLU);
    for (i = 0; i < 8; i++) send_byte(random_text());
    write_line_size(7'd5);
    send_byte(CH_NL);
    send_random(4);

    write_line_size(7'($urandom_range(2, 64)));
    send_random(4);

    // Long receiver hold-off while bytes keep coming
    write_line_size(7'd16);
    hold_request = 1'b1;
    send_random(12);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d input bytes and %0d output items over several line sizes,",
             sb.bytes_taken, sb.results_seen);
    $display("with %0d completed lines and %0d full-line overflows.",
             sb.lines_done, sb.overflows);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
